/* design/prq_pkg.sv */
package prq_pkg;

    // Default sizes, handed to the top level parameters
    localparam int QUEUE_DEPTH_DEF  = 64;
    localparam int PRIORITY_MAX_DEF = 63;
    localparam int ID_COUNT_DEF     = 256;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DUPLICATE = 3'd4
    } t_status;

    // What a cell does at the next edge
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     occupied;  // slot index is below the entry count
        logic     left_ge;   // left neighbor holds priority >= key
        logic     shift;     // take the right neighbor on OP_SHIFT
    } t_cell_ctrl;

endpackage

/* design/prq_if.sv */
interface prq_req_if #(
    parameter int ID_W   = 8,
    parameter int PRIO_W = 6
);
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [ID_W-1:0]   thread_id;
    logic [PRIO_W-1:0] priority_req;

    modport source (output valid, command, thread_id, priority_req, input ready);
    modport sink   (input valid, command, thread_id, priority_req, output ready);
endinterface

interface prq_res_if #(
    parameter int ID_W   = 8,
    parameter int PRIO_W = 6,
    parameter int CNT_W  = 7
);
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [ID_W-1:0]   popped_id;
    logic [PRIO_W-1:0] popped_priority;
    logic [CNT_W-1:0]  occupancy;

    modport source (output valid, status, popped_id, popped_priority, occupancy,
                    input ready);
    modport sink   (input valid, status, popped_id, popped_priority, occupancy,
                    output ready);
endinterface

/* design/prq_cell.sv */
module prq_cell
    import prq_pkg::*;
#(
    parameter int ID_W   = 8,
    parameter int PRIO_W = 6
) (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [ID_W-1:0]   i_key_id,
    input  logic [PRIO_W-1:0] i_key_prio,
    input  logic [ID_W-1:0]   i_left_id,
    input  logic [PRIO_W-1:0] i_left_prio,
    input  logic [ID_W-1:0]   i_right_id,
    input  logic [PRIO_W-1:0] i_right_prio,
    output logic [ID_W-1:0]   o_id,
    output logic [PRIO_W-1:0] o_prio,
    output logic              o_ge,
    output logic              o_match
);

    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_prio;
    logic [ID_W-1:0]   n_id;
    logic [PRIO_W-1:0] n_prio;

    // Local compares against the request key
    assign o_ge    = i_ctrl.occupied && (r_prio >= i_key_prio);
    assign o_match = i_ctrl.occupied && (r_id == i_key_id);
    assign o_id    = r_id;
    assign o_prio  = r_prio;

    // Insert: first cell below the key takes it, cells after it take the left one
    always_comb begin
        n_id   = r_id;
        n_prio = r_prio;
        case (i_ctrl.op)
            OP_INSERT: begin
                if (!i_ctrl.left_ge) begin
                    n_id   = i_left_id;
                    n_prio = i_left_prio;
                end else if (!o_ge) begin
                    n_id   = i_key_id;
                    n_prio = i_key_prio;
                end
            end
            OP_SHIFT: begin
                if (i_ctrl.shift) begin
                    n_id   = i_right_id;
                    n_prio = i_right_prio;
                end
            end
            default: begin
                n_id   = r_id;
                n_prio = r_prio;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prio <= n_prio;
    end

endmodule

/* design/prq_prefix.sv */
module prq_prefix #(
    parameter int N = 64
) (
    input  logic [N-1:0] i_bits,
    output logic [N-1:0] o_prefix
);

    localparam int LV = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0] stage [LV+1];

    assign stage[0] = i_bits;

    // Log-depth prefix OR: bit i is set when any bit at or below i is set
    for (genvar l = 0; l < LV; l++) begin : g_lvl
        for (genvar i = 0; i < N; i++) begin : g_bit
            if (i >= (1 << l)) begin : g_or
                assign stage[l+1][i] = stage[l][i] | stage[l][i-(1<<l)];
            end else begin : g_pass
                assign stage[l+1][i] = stage[l][i];
            end
        end
    end

    assign o_prefix = stage[LV];

endmodule

/* design/priority_ready_queue_unit.sv */
// Channel  Dir  Payload                                             Handshake
// i_req    in   command, thread_id, priority_req                    valid/ready
// o_res    out  status, popped_id, popped_priority, occupancy       valid/ready
//
// Insert, pop, a failed request and an unused command pass the request register and
// the execute state, which commits the result register; update adds a reinsert state
// (remove pass, then insert). No new request is taken until the result commits.
// The queue is a row of cells, each comparing its entry to the key and shifting
// to a neighbor in a single pass after the request register.
// Reset clears the entry count and control; cell contents need no reset.
// i_req.ready is high while idle; a held result stalls only the final commit.
module priority_ready_queue_unit
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int PRIORITY_MAX = PRIORITY_MAX_DEF,
    parameter int ID_COUNT     = ID_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prq_req_if.sink    i_req,
    prq_res_if.source  o_res
);

    localparam int ID_W   = $clog2(ID_COUNT);
    localparam int PRIO_W = $clog2(PRIORITY_MAX + 1);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_REINS = 3'b100
    } t_state;

    t_state            r_state, n_state;
    t_cmd              r_cmd;
    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_prio;
    logic [CNT_W-1:0]  r_count, n_count;

    logic              r_out_valid;
    t_status           r_status;
    logic [ID_W-1:0]   r_pop_id;
    logic [PRIO_W-1:0] r_pop_prio;
    logic [CNT_W-1:0]  r_occ;

    t_status           c_status;
    logic              c_finish;
    logic              c_commit;
    logic              c_accept;
    logic              c_can_out;
    t_cell_op          c_op;
    logic              c_shift_all;
    logic              c_found;
    logic              c_id_ok;

    logic [ID_W-1:0]   cell_id   [QUEUE_DEPTH];
    logic [PRIO_W-1:0] cell_prio [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_ge;
    logic [QUEUE_DEPTH-1:0] cell_left_ge;
    logic [QUEUE_DEPTH-1:0] cell_match;
    logic [QUEUE_DEPTH-1:0] match_pre;
    t_cell_ctrl        cell_ctrl [QUEUE_DEPTH];

    // Request side
    assign i_req.ready = (r_state == S_IDLE);
    assign c_accept    = i_req.valid && i_req.ready;
    assign c_can_out   = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_cmd <= t_cmd'(i_req.command);
            r_id  <= i_req.thread_id;
            r_prio <= (32'(i_req.priority_req) > PRIORITY_MAX) ?
                      PRIO_W'(PRIORITY_MAX) : i_req.priority_req;
        end
    end

    // Left neighbor compare, the first cell always sees a neighbor at or above the key
    assign cell_left_ge = {cell_ge[QUEUE_DEPTH-2:0], 1'b1};

    // Cell row
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        always_comb begin
            cell_ctrl[i].op       = c_op;
            cell_ctrl[i].occupied = (CNT_W'(i) < r_count);
            cell_ctrl[i].left_ge  = cell_left_ge[i];
            cell_ctrl[i].shift    = c_shift_all || match_pre[i];
        end

        prq_cell #(
            .ID_W   (ID_W),
            .PRIO_W (PRIO_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl[i]),
            .i_key_id     (r_id),
            .i_key_prio   (r_prio),
            .i_left_id    ((i == 0) ? r_id   : cell_id[(i == 0) ? 0 : i-1]),
            .i_left_prio  ((i == 0) ? r_prio : cell_prio[(i == 0) ? 0 : i-1]),
            .i_right_id   ((i == QUEUE_DEPTH-1) ? r_id :
                           cell_id[(i == QUEUE_DEPTH-1) ? i : i+1]),
            .i_right_prio ((i == QUEUE_DEPTH-1) ? r_prio :
                           cell_prio[(i == QUEUE_DEPTH-1) ? i : i+1]),
            .o_id         (cell_id[i]),
            .o_prio       (cell_prio[i]),
            .o_ge         (cell_ge[i]),
            .o_match      (cell_match[i])
        );
    end

    // Cells at or after the matching id close the gap on removal
    prq_prefix #(
        .N (QUEUE_DEPTH)
    ) u_prefix (
        .i_bits   (cell_match),
        .o_prefix (match_pre)
    );

    assign c_found = match_pre[QUEUE_DEPTH-1];
    assign c_id_ok = (32'(r_id) < ID_COUNT);

    // Control: decide the operation and the status
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        c_status    = ST_OK;
        c_finish    = 1'b0;
        c_op        = OP_HOLD;
        c_shift_all = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                c_finish = 1'b1;
                case (r_cmd)
                    CMD_INSERT: begin
                        if (!c_id_ok) begin
                            c_status = ST_NOT_FOUND;
                        end else if (c_found) begin
                            c_status = ST_DUPLICATE;
                        end else if (32'(r_count) >= QUEUE_DEPTH) begin
                            c_status = ST_FULL;
                        end else begin
                            c_op    = OP_INSERT;
                            n_count = r_count + 1'b1;
                        end
                    end
                    CMD_POP: begin
                        if (r_count == '0) begin
                            c_status = ST_EMPTY;
                        end else begin
                            c_op        = OP_SHIFT;
                            c_shift_all = 1'b1;
                            n_count     = r_count - 1'b1;
                        end
                    end
                    CMD_UPDATE: begin
                        if (!c_id_ok || !c_found) begin
                            c_status = ST_NOT_FOUND;
                        end else begin
                            c_finish = 1'b0;
                            c_op     = OP_SHIFT;
                            n_count  = r_count - 1'b1;
                            n_state  = S_REINS;
                        end
                    end
                    default: begin
                        c_status = ST_OK;
                    end
                endcase
                // Hold the whole step while the result register is occupied
                if (c_finish) begin
                    if (c_can_out) begin
                        n_state = S_IDLE;
                    end else begin
                        c_op    = OP_HOLD;
                        n_count = r_count;
                    end
                end
            end
            S_REINS: begin
                c_finish = 1'b1;
                if (c_can_out) begin
                    c_op    = OP_INSERT;
                    n_count = r_count + 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign c_commit = c_finish && c_can_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (c_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (c_commit) begin
            r_status <= c_status;
            r_occ    <= n_count;
            if (r_state == S_EXEC && r_cmd == CMD_POP && c_status == ST_OK) begin
                r_pop_id   <= cell_id[0];
                r_pop_prio <= cell_prio[0];
            end else begin
                r_pop_id   <= '0;
                r_pop_prio <= '0;
            end
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.status          = r_status;
    assign o_res.popped_id       = r_pop_id;
    assign o_res.popped_priority = r_pop_prio;
    assign o_res.occupancy       = r_occ;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= QUEUE_DEPTH)
        else $error("entry count above queue depth");

    // The reinsert pass follows a removal pass and may wait on a held result
    a_reins_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REINS) |->
        ($past(r_state) == S_EXEC || $past(r_state) == S_REINS))
        else $error("reinsert pass without a removal pass");

    a_drop_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_commit && c_status != ST_OK) |=> (r_count == $past(r_count)))
        else $error("failed request changed the entry count");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_commit && r_state == S_EXEC && r_cmd == CMD_POP && c_status == ST_OK)
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not remove one entry");

endmodule
